@@ design/csvft_pkg.sv @@
// csvft_pkg: shared types and constants for the CSV field tokenizer.
// No dependencies. Used by the channel interfaces and by csv_field_tokenizer.
package csvft_pkg;

   typedef logic [7:0] byte_type;

   // Event codes carried on the result channel
   typedef enum logic [1:0] {
      EV_BYTE   = 2'd0,
      EV_FIELD  = 2'd1,
      EV_RECORD = 2'd2
   } event_kind_type;

   // Quote tracker, one-hot
   typedef enum logic [2:0] {
      QM_OUT    = 3'b001,
      QM_IN     = 3'b010,
      QM_CLOSED = 3'b100
   } quote_mode_type;

   localparam byte_type CHR_COMMA = 8'h2C;
   localparam byte_type CHR_QUOTE = 8'h22;
   localparam byte_type CHR_CR    = 8'h0D;
   localparam byte_type CHR_LF    = 8'h0A;
   localparam byte_type CHR_DROP0 = 8'hFE;
   localparam byte_type CHR_DROP1 = 8'hFF;

   // Result queue depth (holds at least one item's worth of events twice over)
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      event_kind_type kind;
      byte_type       data;
      logic           last;
   } rsp_item_type;

endpackage

@@ design/csvft_if.sv @@
// csvft_if: valid/ready channel interfaces for the CSV field tokenizer.
// Depends on csvft_pkg for the payload types.
interface csvft_req_if;
   import csvft_pkg::*;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface csvft_rsp_if;
   import csvft_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   byte_type    field_byte;
   logic        last_of_run;

   modport source (output valid, output event_kind, output field_byte, output last_of_run,
                   input ready);
   modport sink   (input valid, input event_kind, input field_byte, input last_of_run,
                   output ready);
endinterface

@@ design/csv_field_tokenizer.sv @@
// csv_field_tokenizer: byte-serial CSV tokenizer, one byte per transaction in,
// field-content / end-of-field / end-of-record events out.
// Depends on csvft_pkg and the channel interfaces in csvft_if.sv.
//
//  channel  | dir | payload                                  | per transaction
//  ---------+-----+------------------------------------------+------------------------
//  req_bus  | in  | data_byte[7:0], end_of_stream            | one byte or end marker
//  rsp_bus  | out | event_kind[1:0], field_byte[7:0], last   | one event (0..2/byte)
//
// Flow: a byte sits in the input register, where the quote tracker
//   decodes it and pushes 0, 1 or 2 events into a 4-entry result queue.
//   Bytes are taken every cycle while the queue has room for their events;
//   sustained rate is bounded by the result side at one event per cycle.
// Reset: synchronous, active high; clears the tracker, the input register
//   valid and the queue pointers.
// Stalls: the input register holds until the queue has room for all of the
//   byte's events; rsp_bus.ready back-pressure never drops or splits a byte.
module csv_field_tokenizer (
   input  logic       clock,
   input  logic       reset,
   csvft_req_if.sink   req_bus,
   csvft_rsp_if.source rsp_bus
);
   import csvft_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   // Input register
   logic     stg_valid_ff, stg_valid_in;
   byte_type stg_byte_ff;
   logic     stg_eos_ff;

   // Tracker state
   quote_mode_type qm_ff, qm_in;
   logic skip_ff, skip_in;
   logic fhb_ff, fhb_in;   // field holds content
   logic rhf_ff, rhf_in;   // record has closed fields

   // Decode results
   logic [1:0]     push_n;
   event_kind_type ev0_kind, ev1_kind;
   byte_type       ev0_byte;
   logic           is_nl;
   logic           stg_adv;
   logic           req_take;

   // Result queue
   rsp_item_type     q_mem [RSP_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;

   // ---------------------------------------------------------------
   // Per-byte decode
   // ---------------------------------------------------------------
   assign is_nl = (stg_byte_ff == CHR_CR) || (stg_byte_ff == CHR_LF);

   always_comb begin
      qm_in    = qm_ff;
      skip_in  = skip_ff;
      fhb_in   = fhb_ff;
      rhf_in   = rhf_ff;
      push_n   = 2'd0;
      ev0_kind = EV_BYTE;
      ev0_byte = stg_byte_ff;
      ev1_kind = EV_RECORD;
      priority if (stg_eos_ff) begin
         // flush: close pending field, then the record if it holds anything; back to reset state
         ev0_kind = fhb_ff ? EV_FIELD : EV_RECORD;
         push_n   = fhb_ff ? 2'd2 : (rhf_ff ? 2'd1 : 2'd0);
         qm_in    = QM_OUT;
         skip_in  = 1'b0;
         fhb_in   = 1'b0;
         rhf_in   = 1'b0;
      end else if (skip_ff) begin
         skip_in = 1'b0;
      end else begin
         unique case (qm_ff)
            QM_IN: begin
               if (stg_byte_ff == CHR_QUOTE) begin
                  qm_in = QM_CLOSED;
               end else begin
                  push_n = 2'd1;
                  fhb_in = 1'b1;
               end
            end
            QM_CLOSED: begin
               priority if (stg_byte_ff == CHR_COMMA) begin
                  ev0_kind = EV_FIELD;
                  push_n   = 2'd1;
                  fhb_in   = 1'b0;
                  rhf_in   = 1'b1;
                  qm_in    = QM_OUT;
               end else if (stg_byte_ff == CHR_QUOTE) begin
                  // doubled quote: literal quote, back inside
                  qm_in  = QM_IN;
                  push_n = 2'd1;
                  fhb_in = 1'b1;
               end else if (is_nl) begin
                  ev0_kind = EV_FIELD;
                  push_n   = 2'd2;
                  fhb_in   = 1'b0;
                  rhf_in   = 1'b0;
                  qm_in    = QM_OUT;
                  skip_in  = (stg_byte_ff == CHR_CR);
               end else begin
                  // malformed: byte taken as content, even the drop codes
                  qm_in  = QM_OUT;
                  push_n = 2'd1;
                  fhb_in = 1'b1;
               end
            end
            default: begin
               // outside quotes
               qm_in = QM_OUT;
               priority if (stg_byte_ff == CHR_QUOTE) begin
                  qm_in = QM_IN;
               end else if (stg_byte_ff == CHR_COMMA) begin
                  ev0_kind = EV_FIELD;
                  push_n   = 2'd1;
                  fhb_in   = 1'b0;
                  rhf_in   = 1'b1;
               end else if (is_nl) begin
                  ev0_kind = EV_FIELD;
                  push_n   = 2'd2;
                  fhb_in   = 1'b0;
                  rhf_in   = 1'b0;
                  skip_in  = (stg_byte_ff == CHR_CR);
               end else if ((stg_byte_ff == CHR_DROP0) || (stg_byte_ff == CHR_DROP1)) begin
                  // dropped
               end else begin
                  push_n = 2'd1;
                  fhb_in = 1'b1;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake and input register
   // ---------------------------------------------------------------
   // Advance only when the queue can absorb every event of this byte;
   // room ignores this cycle's pop so req ready has no path from rsp ready.
   assign stg_adv = stg_valid_ff &&
                    ((CNT_W'(RSP_DEPTH) - cnt_ff) >= CNT_W'(push_n));
   assign req_bus.ready = !stg_valid_ff || stg_adv;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign stg_valid_in  = req_take ? 1'b1 : (stg_adv ? 1'b0 : stg_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      if (req_take) begin
         stg_byte_ff <= req_bus.data_byte;
         stg_eos_ff  <= req_bus.end_of_stream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qm_ff   <= QM_OUT;
         skip_ff <= 1'b0;
         fhb_ff  <= 1'b0;
         rhf_ff  <= 1'b0;
      end else if (stg_adv) begin
         qm_ff   <= qm_in;
         skip_ff <= skip_in;
         fhb_ff  <= fhb_in;
         rhf_ff  <= rhf_in;
      end
   end

   // ---------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------
   assign pop     = rsp_bus.valid && rsp_bus.ready;
   assign head_in = pop ? head_ff + PTR_W'(1) : head_ff;
   assign tail_in = stg_adv ? tail_ff + PTR_W'(push_n) : tail_ff;
   assign cnt_in  = cnt_ff + (stg_adv ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_adv && (push_n != 2'd0)) begin
         q_mem[tail_ff] <= '{kind: ev0_kind,
                             data: (ev0_kind == EV_BYTE) ? ev0_byte : '0,
                             last: (push_n == 2'd1)};
      end
      if (stg_adv && (push_n == 2'd2)) begin
         q_mem[tail_ff + PTR_W'(1)] <= '{kind: ev1_kind, data: '0, last: 1'b1};
      end
   end

   assign rsp_bus.valid       = (cnt_ff != '0);
   assign rsp_bus.event_kind  = q_mem[head_ff].kind;
   assign rsp_bus.field_byte  = q_mem[head_ff].data;
   assign rsp_bus.last_of_run = q_mem[head_ff].last;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stg_adv |-> ({1'b0, cnt_ff} + {{(CNT_W-1){1'b0}}, push_n}) <= (CNT_W+1)'(RSP_DEPTH))
      else $error("byte advanced without queue room");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (stg_adv && stg_eos_ff) |=> (qm_ff == QM_OUT) && !skip_ff && !fhb_ff && !rhf_ff)
      else $error("end of stream did not clear tracker");

   a_skip_after_cr: assert property (@(posedge clock) disable iff (reset)
      $rose(skip_ff) |-> ($past(stg_byte_ff) == CHR_CR) && !$past(stg_eos_ff))
      else $error("skip set by a byte other than CR");

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for csv_field_tokenizer, random bursts of idling on both channels.
// Depends on csvft_pkg and the channel interfaces in csvft_if.sv; needs nothing else.
// Directed table first, then random CSV-shaped streams, checked by a predictor or by typed rows.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import csvft_pkg::*;

   // One row of stimulus. Where typed is set, ev0/ev1 hold the expected events (n_ev of
   // them) and replace the predictor's output for that transaction.
   typedef struct packed {
      byte_type     data;
      logic         eos;
      logic         typed;
      logic [1:0]   n_ev;
      rsp_item_type ev0;
      rsp_item_type ev1;
   } stim_row_type;

   localparam rsp_item_type NO_EVENT        = '0;
   localparam int           HOLD_OFF_CYCLES = 80;
   localparam int           CALM_ITEMS      = 60;
   localparam int           RANDOM_ITEMS    = 420;

   logic clock;
   logic reset;

   csvft_req_if req_bus ();
   csvft_rsp_if rsp_bus ();

   csv_field_tokenizer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Stimulus, in offer order; the checker pops one row per accepted request transaction
   stim_row_type byte_stream [$];
   stim_row_type offered_bytes [$];
   // Events still owed by the block, oldest first
   rsp_item_type expected_events [$];
   // Scratch: events produced by the predictor for one byte
   rsp_item_type step_events [$];

   int  mismatches   = 0;
   bit  hold_off_req = 1'b0;   // sender asks the receiver for one long stall
   bit  calm_tail    = 1'b0;   // last stretch of the run: no idling anywhere
   bit  tx_idling    = 1'b1;
   bit  rx_idling    = 1'b1;

   // Predictor copy of the tokenizer state
   quote_mode_type quote_state;
   bit             skip_pending;
   bit             field_busy;
   bit             record_busy;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic void clear_tracker();
      quote_state  = QM_OUT;
      skip_pending = 1'b0;
      field_busy   = 1'b0;
      record_busy  = 1'b0;
   endfunction

   function automatic void push_event(event_kind_type k, byte_type d);
      rsp_item_type e;
      e.kind = k;
      e.data = d;
      e.last = 1'b0;
      step_events.insert(step_events.size(), e);
   endfunction

   function automatic void take_content(byte_type d);
      push_event(EV_BYTE, d);
      field_busy = 1'b1;
   endfunction

   function automatic void close_field();
      push_event(EV_FIELD, '0);
      field_busy  = 1'b0;
      record_busy = 1'b1;
   endfunction

   // A record end always carries its own end of field first
   function automatic void close_record();
      close_field();
      push_event(EV_RECORD, '0);
      field_busy  = 1'b0;
      record_busy = 1'b0;
      quote_state = QM_OUT;
   endfunction

   // Works out the events that one accepted byte (or end marker) produces
   function automatic void tokenize_byte(byte_type c, logic eos);
      step_events.delete();
      if (eos) begin
         // flush: pending field, then the record if anything was closed in it
         if (field_busy)
            push_event(EV_FIELD, '0);
         if (field_busy || record_busy)
            push_event(EV_RECORD, '0);
         clear_tracker();
      end else if (skip_pending) begin
         // byte after a record-ending CR is swallowed, whatever it is
         skip_pending = 1'b0;
      end else begin
         case (quote_state)
            QM_IN: begin
               if (c == CHR_QUOTE)
                  quote_state = QM_CLOSED;
               else
                  take_content(c);
            end
            QM_CLOSED: begin
               if (c == CHR_COMMA) begin
                  close_field();
                  quote_state = QM_OUT;
               end else if (c == CHR_QUOTE) begin
                  // doubled quote: literal quote, back inside
                  quote_state = QM_IN;
                  take_content(c);
               end else if (c == CHR_CR || c == CHR_LF) begin
                  skip_pending = (c == CHR_CR);
                  close_record();
               end else begin
                  // malformed trailer: kept as content, drop bytes included
                  quote_state = QM_OUT;
                  take_content(c);
               end
            end
            default: begin
               quote_state = QM_OUT;
               if (c == CHR_QUOTE)
                  quote_state = QM_IN;
               else if (c == CHR_COMMA)
                  close_field();
               else if (c == CHR_CR || c == CHR_LF) begin
                  skip_pending = (c == CHR_CR);
                  close_record();
               end else if (c != CHR_DROP0 && c != CHR_DROP1)
                  take_content(c);
            end
         endcase
      end
      if (step_events.size() > 0)
         step_events[step_events.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic rsp_item_type ev(event_kind_type k, byte_type d, logic l);
      rsp_item_type e;
      e.kind = k;
      e.data = d;
      e.last = l;
      return e;
   endfunction

   function automatic stim_row_type mk(byte_type d, logic e, logic typed, logic [1:0] n,
                                       rsp_item_type a, rsp_item_type b);
      stim_row_type r;
      r.data  = d;
      r.eos   = e;
      r.typed = typed;
      r.n_ev  = n;
      r.ev0   = a;
      r.ev1   = b;
      return r;
   endfunction

   function automatic void append_row(stim_row_type r);
      byte_stream.insert(byte_stream.size(), r);
   endfunction

   function automatic void add_byte(byte_type d);
      append_row(mk(d, 1'b0, 1'b0, 2'd0, NO_EVENT, NO_EVENT));
   endfunction

   function automatic void add_eos();
      append_row(mk(byte_type'($urandom_range(0, 255)), 1'b1, 1'b0, 2'd0, NO_EVENT,
                    NO_EVENT));
   endfunction

   // Random byte that carries no CSV meaning (drop bytes allowed)
   function automatic byte_type plain_byte();
      byte_type c;
      do
         c = byte_type'($urandom_range(0, 255));
      while (c == CHR_COMMA || c == CHR_QUOTE || c == CHR_CR || c == CHR_LF);
      return c;
   endfunction

   task automatic send_row(stim_row_type r);
      offered_bytes.insert(offered_bytes.size(), r);
      req_bus.valid         <= 1'b1;
      req_bus.data_byte     <= r.data;
      req_bus.end_of_stream <= r.eos;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   initial begin : stimulus
      int       idx;
      int       pause_at;
      int       hold_at;
      int       calm_from;
      int       n_fields;
      int       len;
      int       style;
      int       drain;
      byte_type c;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.data_byte     = '0;
      req_bus.end_of_stream = 1'b0;

      // Directed table: quote tracker walk, drop bytes, skip after CR, flushes
      append_row(mk(8'h00, 1'b1, 1'b1, 2'd0, NO_EVENT, NO_EVENT)); // eos, empty
      append_row(mk(8'h00, 1'b0, 1'b1, 2'd1, ev(EV_BYTE, 8'h00, 1'b1), NO_EVENT));
      append_row(mk(CHR_DROP1, 1'b0, 1'b1, 2'd0, NO_EVENT, NO_EVENT));
      append_row(mk(CHR_DROP0, 1'b0, 1'b1, 2'd0, NO_EVENT, NO_EVENT));
      append_row(mk(CHR_COMMA, 1'b0, 1'b1, 2'd1, ev(EV_FIELD, 8'h00, 1'b1), NO_EVENT));
      add_byte(CHR_QUOTE);      // open quote
      add_byte(CHR_DROP1);      // content inside quotes
      add_byte(CHR_LF);         // LF inside quotes is content
      add_byte(CHR_QUOTE);      // closing quote
      add_byte(CHR_QUOTE);      // doubled quote
      add_byte(CHR_QUOTE);
      add_byte(CHR_DROP0);      // malformed byte after closing quote, kept
      add_byte(CHR_QUOTE);
      add_byte(CHR_QUOTE);
      add_byte(CHR_COMMA);      // comma after closing quote
      add_byte(CHR_QUOTE);
      add_byte(CHR_QUOTE);
      add_byte(CHR_CR);         // CR after closing quote: record end, then skip
      add_byte(CHR_QUOTE);      // swallowed
      add_byte(CHR_LF);         // empty record
      add_byte(8'h61);
      add_eos();                // flush with content pending
      add_byte(CHR_CR);
      add_eos();                // flush clears a pending skip
      add_byte(CHR_QUOTE);
      add_eos();                // stream ends inside quotes
      append_row(mk(8'h80, 1'b0, 1'b1, 2'd1, ev(EV_BYTE, 8'h80, 1'b1), NO_EVENT));

      pause_at = byte_stream.size() + 100;
      hold_at  = byte_stream.size() + 220;

      // Random part: mostly well-formed records, some noise
      while (byte_stream.size() < 27 + RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
               case ($urandom_range(0, 5))
                  0: add_byte(CHR_QUOTE);
                  1: add_byte(CHR_COMMA);
                  2: add_byte(CHR_CR);
                  3: add_byte(CHR_LF);
                  4: add_eos();
                  default: add_byte(byte_type'($urandom_range(0, 255)));
               endcase
            end
         end else begin
            n_fields = $urandom_range(1, 4);
            for (int f = 0; f < n_fields; f++) begin
               if (f > 0)
                  add_byte(CHR_COMMA);
               style = $urandom_range(0, 4);
               len   = $urandom_range(0, 5);
               if (style < 2) begin
                  repeat (len) add_byte(plain_byte());
               end else begin
                  add_byte(CHR_QUOTE);
                  repeat (len) begin
                     c = byte_type'($urandom_range(0, 255));
                     if ($urandom_range(0, 5) == 0)
                        c = CHR_QUOTE;
                     add_byte(c);
                     if (c == CHR_QUOTE)
                        add_byte(CHR_QUOTE);
                  end
                  add_byte(CHR_QUOTE);
                  if (style == 4)
                     add_byte(plain_byte());   // junk after the closing quote
               end
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: add_byte(CHR_LF);
               5, 6: begin
                  add_byte(CHR_CR);
                  add_byte(CHR_LF);
               end
               7: begin
                  add_byte(CHR_CR);
                  add_byte(byte_type'($urandom_range(0, 255)));
               end
               8: add_eos();
               default: ;
            endcase
         end
      end
      add_eos();
      calm_from = byte_stream.size() - CALM_ITEMS;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (idx = 0; idx < byte_stream.size(); idx++) begin
         if (idx >= calm_from)
            calm_tail = 1'b1;
         send_row(byte_stream[idx]);
         if (idx == pause_at) begin
            // sender waits until the block has handed over everything it owes
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (expected_events.size() != 0 || offered_bytes.size() != 0)
               @(posedge clock);
         end else if (idx == hold_at) begin
            // receiver stalls for a long stretch; keep offering back to back
            hold_off_req = 1'b1;
         end else if (tx_idling && !calm_tail && !(idx > hold_at && idx < hold_at + 40)
                      && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         if ($urandom_range(0, 31) == 0)
            tx_idling = !tx_idling;
      end
      req_bus.valid <= 1'b0;

      drain = 0;
      while (drain < 5000 && (expected_events.size() != 0 || offered_bytes.size() != 0)) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (expected_events.size() != 0) begin
         $display("%0t ns: %0d expected event(s) never arrived", $time, expected_events.size());
         mismatches++;
      end

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!calm_tail && rx_idling && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 13);
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 39) == 0)
               rx_idling = !rx_idling;
         end
      end
   end

   // ------------------------------------------------------------------
   // Checker: both handshakes sampled at the same edge, request side first,
   // so an expectation always exists before its result transaction is seen.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      stim_row_type row;
      rsp_item_type want;
      if (reset) begin
         clear_tracker();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            row = offered_bytes.pop_front();
            tokenize_byte(row.data, row.eos);   // state advances on every row
            if (row.typed) begin
               if (row.n_ev >= 2'd1)
                  expected_events.insert(expected_events.size(), row.ev0);
               if (row.n_ev == 2'd2)
                  expected_events.insert(expected_events.size(), row.ev1);
            end else begin
               foreach (step_events[i])
                  expected_events.insert(expected_events.size(), step_events[i]);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_events.size() == 0) begin
               $display("%0t ns: unexpected event, expected none, actual kind %0d byte %h last %b",
                        $time, rsp_bus.event_kind, rsp_bus.field_byte, rsp_bus.last_of_run);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_bus.event_kind !== want.kind) begin
                  $display("%0t ns: event_kind expected %0d actual %0d",
                           $time, want.kind, rsp_bus.event_kind);
                  mismatches++;
               end
               if (rsp_bus.field_byte !== want.data) begin
                  $display("%0t ns: field_byte expected %h actual %h",
                           $time, want.data, rsp_bus.field_byte);
                  mismatches++;
               end
               if (rsp_bus.last_of_run !== want.last) begin
                  $display("%0t ns: last_of_run expected %b actual %b",
                           $time, want.last, rsp_bus.last_of_run);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #400000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
design/csvft_pkg.sv
design/csvft_if.sv
design/csv_field_tokenizer.sv
tb/tb.sv
